// File: rtl/sorted_array_occurrence_counter_assert.svh
// Assertion macros used by the checker file.
// No dependencies; pulled in by `include.
`ifndef SORTED_ARRAY_OCCURRENCE_COUNTER_ASSERT_SVH
`define SORTED_ARRAY_OCCURRENCE_COUNTER_ASSERT_SVH

// Clocked check, off while reset is asserted.
`define SAOC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("saoc assertion failed");

// Clocked check that also holds across reset.
`define SAOC_ASSERT_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("saoc assertion failed");

`endif

// File: rtl/saoc_pkg.sv
// Shared types and codes for the sorted array occurrence counter.
// No dependencies.
package saoc_pkg;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    localparam int IDX_W = 10;
    localparam int CNT_W = 11;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] value;
    } t_in_word;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] first_index;
        logic [IDX_W-1:0] last_index;
        logic [CNT_W-1:0] occurrence_count;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_NB,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clear;
        logic append;
        logic start;
        logic probe;
        logic nb_read;
        logic step_lo;
        logic step_hi;
        logic hit;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic lo_lt_hi;
        logic eq;
        logic gt;
        logic edge_hit;
        logic pass_last;
    } t_status;

endpackage

// File: rtl/sorted_array_occurrence_counter.sv
// Sorted array occurrence counter: input word is {mode, value}.
// Clear empties the store; append writes value at the next position (ignored when full);
// query returns {found, first_index, last_index, occurrence_count}, found zero when absent.
// Both channels are valid/ready; a word moves when valid and ready are high at a clock edge.
// Clear and append produce no output word.
// A query runs a first-occurrence binary search, then, if found, a last-occurrence search.
// Each probe drives the address in S_PROBE, then compares the registered RAM read in S_CMP;
// an equal probe that is not at the array edge then reads its neighbor in S_NB.
// Each search makes at most ceil(log2(n+1)) probes, n being the stored element count.
// The RAM read port is shared by every probe and neighbor read, and no new input word is
// taken until a query finishes.
// The result waits in an output register; with it full, the next append or clear is still
// taken, and a new query finishes its search and then holds until the register drains.
// Reset empties the store and drops any pending result; stored data is not cleared.
// Depends on saoc_pkg, saoc_ctrl, saoc_dp.
module sorted_array_occurrence_counter #(
    parameter int CAPACITY = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  saoc_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output saoc_pkg::t_out_word o_out_data
);

    saoc_pkg::t_cmd    w_cmd;
    saoc_pkg::t_status w_status;

    saoc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_mode      (i_in_data.mode),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    saoc_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_out_data (o_out_data)
    );

endmodule

// File: rtl/saoc_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module saoc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/saoc_dp.sv
// Datapath: element store, search bounds, probe compare and result register.
// Depends on saoc_pkg and saoc_ram.
module saoc_dp #(
    parameter int CAPACITY = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  saoc_pkg::t_in_word   i_in_data,
    input  saoc_pkg::t_cmd       i_cmd,
    output saoc_pkg::t_status    o_status,
    output saoc_pkg::t_out_word  o_out_data
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (AW > saoc_pkg::CNT_W) ? AW : saoc_pkg::CNT_W;

    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_lo;
    logic [CW-1:0]       r_hi_ex;
    logic [AW-1:0]       r_mid;
    logic [AW-1:0]       r_first;
    logic [AW-1:0]       r_last;
    logic                r_found;
    logic                r_last_ok;
    logic                r_pass;
    logic signed [31:0]  r_target;
    saoc_pkg::t_out_word r_out;

    logic [CW:0]         w_sum;
    logic [AW-1:0]       w_mid;
    logic [AW-1:0]       w_nb;
    logic                w_rd_en;
    logic [AW-1:0]       w_rd_addr;
    logic signed [31:0]  w_rd_data;
    logic [XW-1:0]       w_first_x;
    logic [XW-1:0]       w_last_x;
    logic [XW-1:0]       w_cnt_x;
    saoc_pkg::t_out_word n_out;

    // mid = (lo + hi) / 2 with hi = hi_ex - 1; only used while lo < hi_ex
    assign w_sum = {1'b0, r_lo} + {1'b0, r_hi_ex} - (CW+1)'(1);
    assign w_mid = w_sum[AW:1];
    assign w_nb  = r_pass ? (r_mid + AW'(1)) : (r_mid - AW'(1));

    assign w_rd_en   = i_cmd.probe | i_cmd.nb_read;
    assign w_rd_addr = i_cmd.probe ? w_mid : w_nb;

    saoc_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.append),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (i_in_data.value),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
        end else if (i_cmd.append) begin
            r_count <= r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_target  <= i_in_data.value;
            r_lo      <= '0;
            r_hi_ex   <= r_count;
            r_pass    <= 1'b0;
            r_found   <= 1'b0;
            r_last_ok <= 1'b0;
        end else if (i_cmd.hit) begin
            if (r_pass) begin
                r_last    <= r_mid;
                r_last_ok <= 1'b1;
            end else begin
                r_first <= r_mid;
                r_found <= 1'b1;
                r_lo    <= '0;
                r_hi_ex <= r_count;
                r_pass  <= 1'b1;
            end
        end else if (i_cmd.step_lo) begin
            r_lo <= CW'(r_mid) + CW'(1);
        end else if (i_cmd.step_hi) begin
            r_hi_ex <= CW'(r_mid);
        end
        if (i_cmd.probe) begin
            r_mid <= w_mid;
        end
        if (i_cmd.load_out) begin
            r_out <= n_out;
        end
    end

    // a missing last index counts as -1
    always_comb begin
        w_first_x = XW'(r_first);
        w_last_x  = XW'(r_last);
        w_cnt_x   = r_last_ok ? (w_last_x - w_first_x + XW'(1)) : (XW'(0) - w_first_x);
        n_out     = '0;
        if (r_found) begin
            n_out.found            = 1'b1;
            n_out.first_index      = w_first_x[saoc_pkg::IDX_W-1:0];
            n_out.last_index       = r_last_ok ? w_last_x[saoc_pkg::IDX_W-1:0] : '0;
            n_out.occurrence_count = w_cnt_x[saoc_pkg::CNT_W-1:0];
        end
    end

    assign o_status.full      = (r_count == CW'(CAPACITY));
    assign o_status.lo_lt_hi  = (r_lo < r_hi_ex);
    assign o_status.eq        = (w_rd_data == r_target);
    assign o_status.gt        = (w_rd_data > r_target);
    assign o_status.edge_hit  = r_pass ? ((CW'(r_mid) + CW'(1)) == r_count)
                                       : (r_mid == '0);
    assign o_status.pass_last = r_pass;

    assign o_out_data = r_out;

endmodule

// File: rtl/saoc_ctrl.sv
// Controller FSM: sequences appends, clears and the two binary searches.
// Depends on saoc_pkg.
module saoc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_mode,
    input  logic              i_out_ready,
    input  saoc_pkg::t_status i_status,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output saoc_pkg::t_cmd    o_cmd
);

    saoc_pkg::t_state r_state;
    saoc_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             w_accept;
    logic             w_out_free;

    assign o_in_ready = (r_state == saoc_pkg::S_IDLE);
    assign w_accept   = i_in_valid & o_in_ready;
    assign w_out_free = ~r_out_valid | i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= saoc_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            saoc_pkg::S_IDLE: begin
                if (w_accept && i_mode == saoc_pkg::MODE_QUERY) begin
                    n_state = saoc_pkg::S_PROBE;
                end
            end
            saoc_pkg::S_PROBE: begin
                n_state = i_status.lo_lt_hi ? saoc_pkg::S_CMP : saoc_pkg::S_DONE;
            end
            saoc_pkg::S_CMP: begin
                if (!i_status.eq) begin
                    n_state = saoc_pkg::S_PROBE;
                end else if (!i_status.edge_hit) begin
                    n_state = saoc_pkg::S_NB;
                end else begin
                    n_state = i_status.pass_last ? saoc_pkg::S_DONE : saoc_pkg::S_PROBE;
                end
            end
            saoc_pkg::S_NB: begin
                if (!i_status.eq && i_status.pass_last) begin
                    n_state = saoc_pkg::S_DONE;
                end else begin
                    n_state = saoc_pkg::S_PROBE;
                end
            end
            saoc_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = saoc_pkg::S_IDLE;
                end
            end
            default: n_state = saoc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        n_out_valid = r_out_valid & ~i_out_ready;
        case (r_state)
            saoc_pkg::S_IDLE: begin
                o_cmd.clear  = w_accept && (i_mode == saoc_pkg::MODE_CLEAR);
                o_cmd.append = w_accept && (i_mode == saoc_pkg::MODE_APPEND)
                               && !i_status.full;
                o_cmd.start  = w_accept && (i_mode == saoc_pkg::MODE_QUERY);
            end
            saoc_pkg::S_PROBE: begin
                o_cmd.probe = i_status.lo_lt_hi;
            end
            saoc_pkg::S_CMP: begin
                if (!i_status.eq) begin
                    o_cmd.step_hi = i_status.gt;
                    o_cmd.step_lo = ~i_status.gt;
                end else if (!i_status.edge_hit) begin
                    o_cmd.nb_read = 1'b1;
                end else begin
                    o_cmd.hit = 1'b1;
                end
            end
            saoc_pkg::S_NB: begin
                if (!i_status.eq) begin
                    o_cmd.hit = 1'b1;
                end else begin
                    o_cmd.step_lo = i_status.pass_last;
                    o_cmd.step_hi = ~i_status.pass_last;
                end
            end
            saoc_pkg::S_DONE: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/saoc_checker.sv
// Port-level checks for the occurrence counter, bound to the top level.
// Depends on saoc_pkg and sorted_array_occurrence_counter_assert.svh.
`include "sorted_array_occurrence_counter_assert.svh"

module saoc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input saoc_pkg::t_in_word  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input saoc_pkg::t_out_word o_out_data
);

    logic w_out_stall;
    logic w_out_miss;
    logic w_zero_word;
    logic w_query_take;

    assign w_out_stall  = o_out_valid && !i_out_ready;
    assign w_out_miss   = o_out_valid && !o_out_data.found;
    assign w_zero_word  = (o_out_data.first_index == '0) && (o_out_data.last_index == '0)
                          && (o_out_data.occurrence_count == '0);
    assign w_query_take = i_in_valid && o_in_ready
                          && (i_in_data.mode == saoc_pkg::MODE_QUERY);

    `SAOC_ASSERT(a_out_hold, i_clk, i_rst_n, w_out_stall |=> o_out_valid && $stable(o_out_data))
    `SAOC_ASSERT(a_miss_zero, i_clk, i_rst_n, w_out_miss |-> w_zero_word)
    `SAOC_ASSERT(a_query_busy, i_clk, i_rst_n, w_query_take |=> !o_in_ready)
    `SAOC_ASSERT(a_result_after_busy, i_clk, i_rst_n, $rose(o_out_valid) |-> !$past(o_in_ready))
    `SAOC_ASSERT_NORST(a_reset_drops, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

bind sorted_array_occurrence_counter saoc_checker u_saoc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
